// ===== hdl/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

    typedef enum logic [2:0] {
        FUNC_START = 3'd0,
        FUNC_STOP  = 3'd1,
        FUNC_WAIT  = 3'd2,
        FUNC_ACK   = 3'd3,
        FUNC_WRITE = 3'd4,
        FUNC_READ  = 3'd5
    } func_t;

    localparam int StepW = 5;
    localparam int PhaseW = 2;
    localparam int DataW = 32;
    localparam int AddrW = 3;

    localparam logic [StepW-1:0] WRITE_LAST_STEP = 5'd24;
    localparam logic [StepW-1:0] READ_BIT_STEPS = 5'd16;

    localparam logic [PhaseW-1:0] PH_DATA = 2'd0;
    localparam logic [PhaseW-1:0] PH_RISE = 2'd1;
    localparam logic [PhaseW-1:0] PH_FALL = 2'd2;

    localparam logic [7:0] DEFAULT_POLL_LIMIT = 8'd250;
    localparam logic [7:0] NEVER_LOW = 8'hFF;

    localparam logic REG_POLL_LIMIT = 1'b0;

endpackage

`default_nettype wire

// ===== hdl/i2cbm_ifs.sv =====
`default_nettype none

interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       ack_choice;
    logic [7:0] rx_bits;
    logic [7:0] sda_high_polls;

    modport source (output valid, func, tx_byte, ack_choice, rx_bits, sda_high_polls,
                    input ready);
    modport sink (input valid, func, tx_byte, ack_choice, rx_bits, sda_high_polls,
                  output ready);
endinterface

interface i2cbm_pin_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] rx_byte;
    logic       ack_failed;
    logic       last;

    modport source (output valid, scl_level, sda_level, sda_drive, rx_byte, ack_failed, last,
                    input ready);
    modport sink (input valid, scl_level, sda_level, sda_drive, rx_byte, ack_failed, last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/i2c_bit_level_master_sequencer_unit.sv =====
`default_nettype none

// I2C master bit sequencer. Each command item expands into its pin updates, one
// result item per clock unless pins.ready stalls: start, stop and send-ack give
// 4 updates, wait-ack 3 (or 6 when it times out and appends a stop), read byte 20
// and write byte 25. The pace is set by the single step counter that walks the
// current command; the next command is taken in the same cycle its final update
// is loaded into the output register, so commands run back to back with no gap.
// Undefined codes are dropped with no output. ack_poll_limit is at byte address 0.
module i2c_bit_level_master_sequencer_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    i2cbm_cmd_if.sink                    cmd,
    i2cbm_pin_if.source                  pins,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [i2cbm_pkg::AddrW-1:0]   paddr,
    input  wire [i2cbm_pkg::DataW-1:0]   pwdata,
    output logic [i2cbm_pkg::DataW-1:0]  prdata,
    output logic                         pready
);
    import i2cbm_pkg::*;

    logic [7:0]        limit_reg;

    logic              scl_reg;
    logic              sda_reg;
    logic              drive_reg;

    logic              busy_reg;
    func_t             func_reg;
    logic [7:0]        shift_reg;
    logic              ack_reg;
    logic [7:0]        rx_reg;
    logic              fail_reg;
    logic [StepW-1:0]  step_reg;
    logic [PhaseW-1:0] phase_reg;

    logic              out_valid_reg;
    logic              out_scl_reg;
    logic              out_sda_reg;
    logic              out_drive_reg;
    logic [7:0]        out_rx_reg;
    logic              out_fail_reg;
    logic              out_last_reg;

    logic              scl_next;
    logic              sda_next;
    logic              drive_next;
    logic              cur_last;
    logic [7:0]        cur_rx;
    logic              cur_fail;
    logic              adv;
    logic              accept;
    logic              cmd_known;
    logic              cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_POLL_LIMIT) ? {{(DataW-8){1'b0}}, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= DEFAULT_POLL_LIMIT;
        end
        else if (cfg_write && (paddr[2] == REG_POLL_LIMIT))
        begin
            limit_reg <= pwdata[7:0];
        end
    end

    // handshake
    assign adv       = busy_reg && (!out_valid_reg || pins.ready);
    assign cmd.ready = !busy_reg || (adv && cur_last);
    assign accept    = cmd.valid && cmd.ready;
    assign cmd_known = (cmd.func <= FUNC_READ);

    // one pin update per step
    always_comb
    begin
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        cur_last   = 1'b0;
        cur_rx     = '0;
        cur_fail   = 1'b0;
        case (func_reg)
            FUNC_START:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        drive_next = 1'b1;
                        sda_next   = 1'b1;
                    end
                    5'd1: scl_next = 1'b1;
                    5'd2: sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        cur_last = 1'b1;
                    end
                endcase
            end
            FUNC_STOP:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                    end
                    5'd1: sda_next = 1'b0;
                    5'd2: scl_next = 1'b1;
                    default:
                    begin
                        sda_next = 1'b1;
                        cur_last = 1'b1;
                    end
                endcase
            end
            FUNC_WAIT:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                    end
                    5'd1: scl_next = 1'b1;
                    5'd2:
                    begin
                        scl_next = 1'b0;
                        if (fail_reg)
                        begin
                            drive_next = 1'b1;
                        end
                        else
                        begin
                            cur_last = 1'b1;
                        end
                    end
                    5'd3: sda_next = 1'b0;
                    5'd4: scl_next = 1'b1;
                    default:
                    begin
                        sda_next = 1'b1;
                        cur_last = 1'b1;
                        cur_fail = 1'b1;
                    end
                endcase
            end
            FUNC_ACK:
            begin
                case (step_reg)
                    5'd0: scl_next = 1'b0;
                    5'd1:
                    begin
                        drive_next = 1'b1;
                        sda_next   = !ack_reg;
                    end
                    5'd2: scl_next = 1'b1;
                    default:
                    begin
                        scl_next = 1'b0;
                        cur_last = 1'b1;
                    end
                endcase
            end
            FUNC_WRITE:
            begin
                drive_next = 1'b1;
                case (phase_reg)
                    PH_DATA: sda_next = shift_reg[7];
                    PH_RISE: scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
                cur_last = (step_reg == WRITE_LAST_STEP);
            end
            FUNC_READ:
            begin
                if (step_reg < READ_BIT_STEPS)
                begin
                    drive_next = 1'b0;
                    scl_next   = step_reg[0];
                end
                else
                begin
                    case (step_reg[1:0])
                        2'd0: scl_next = 1'b0;
                        2'd1:
                        begin
                            drive_next = 1'b1;
                            sda_next   = !ack_reg;
                        end
                        2'd2: scl_next = 1'b1;
                        default:
                        begin
                            scl_next = 1'b0;
                            cur_last = 1'b1;
                            cur_rx   = rx_reg;
                        end
                    endcase
                end
            end
            default: cur_last = 1'b1;
        endcase
    end

    // command register and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            func_reg  <= FUNC_START;
            step_reg  <= '0;
            phase_reg <= PH_FALL;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drive_reg <= 1'b1;
        end
        else
        begin
            if (adv)
            begin
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                drive_reg <= drive_next;
            end
            if (accept)
            begin
                busy_reg  <= cmd_known;
                func_reg  <= func_t'(cmd.func);
                step_reg  <= '0;
                phase_reg <= PH_FALL;
            end
            else if (adv)
            begin
                step_reg  <= step_reg + 1'b1;
                phase_reg <= (phase_reg == PH_FALL) ? PH_DATA : phase_reg + 1'b1;
                if (cur_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            shift_reg <= cmd.tx_byte;
            ack_reg   <= cmd.ack_choice;
            rx_reg    <= cmd.rx_bits;
            fail_reg  <= (cmd.sda_high_polls > limit_reg) || (cmd.sda_high_polls == NEVER_LOW);
        end
        else if (adv && (func_reg == FUNC_WRITE) && (phase_reg == PH_DATA))
        begin
            shift_reg <= {shift_reg[6:0], 1'b0};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pins.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_scl_reg   <= scl_next;
            out_sda_reg   <= sda_next;
            out_drive_reg <= drive_next;
            out_rx_reg    <= cur_rx;
            out_fail_reg  <= cur_fail;
            out_last_reg  <= cur_last;
        end
    end

    assign pins.valid      = out_valid_reg;
    assign pins.scl_level  = out_scl_reg;
    assign pins.sda_level  = out_sda_reg;
    assign pins.sda_drive  = out_drive_reg;
    assign pins.rx_byte    = out_rx_reg;
    assign pins.ack_failed = out_fail_reg;
    assign pins.last       = out_last_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= WRITE_LAST_STEP))
        else $error("step counter ran past the longest sequence");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && cur_last && !accept) |=> !busy_reg)
        else $error("sequencer stayed busy after final update");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_known) |=> (busy_reg && (step_reg == '0)))
        else $error("accepted command did not start at step zero");

    a_fail_ends_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fail_reg) |-> (out_scl_reg && out_sda_reg && out_drive_reg
                                             && out_last_reg))
        else $error("ack timeout did not end on a stop condition");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
    import i2cbm_pkg::*;

    localparam logic [AddrW-1:0] ADDR_POLL_LIMIT = AddrW'(4 * REG_POLL_LIMIT);
    localparam logic [AddrW-1:0] ADDR_UNMAPPED = AddrW'(4);
    localparam logic [2:0] FUNC_UNDEF_LO = 3'd6;
    localparam logic [2:0] FUNC_UNDEF_HI = 3'd7;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_LIMIT = 20000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_choice;
        logic [7:0] rx_bits;
        logic [7:0] sda_high_polls;
    } bus_cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic [7:0] rx_byte;
        logic       ack_failed;
        logic       last;
    } pin_upd_t;

    typedef struct packed {
        bus_cmd_t   c;
        bit         typed;
        logic [7:0] exp_rx;
        bit         exp_fail;
    } dir_row_t;

    localparam int NDIR = 22;

    // typed rows pin down the final update's rx_byte / ack_failed
    dir_row_t dir_rows [NDIR] = '{
        '{'{FUNC_START,    8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_WRITE,    8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_WRITE,    8'hFF, 1'b1, 8'hFF, 8'hFF}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_WAIT,     8'h00, 1'b0, 8'h00, 8'd0},   1'b1, 8'h00, 1'b0},
        '{'{FUNC_WAIT,     8'hFF, 1'b1, 8'hFF, 8'd250}, 1'b1, 8'h00, 1'b0},
        '{'{FUNC_WAIT,     8'h00, 1'b0, 8'h00, 8'd251}, 1'b1, 8'h00, 1'b1},
        '{'{FUNC_WAIT,     8'hFF, 1'b1, 8'hFF, 8'd255}, 1'b1, 8'h00, 1'b1},
        '{'{FUNC_ACK,      8'h00, 1'b1, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_ACK,      8'hFF, 1'b0, 8'hFF, 8'hFF}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_READ,     8'h00, 1'b1, 8'h00, 8'h00}, 1'b1, 8'h00, 1'b0},
        '{'{FUNC_READ,     8'hFF, 1'b0, 8'hFF, 8'hFF}, 1'b1, 8'hFF, 1'b0},
        '{'{FUNC_READ,     8'h3C, 1'b1, 8'hA5, 8'h01}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_WRITE,    8'h5A, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_UNDEF_LO, 8'hFF, 1'b1, 8'hFF, 8'hFF}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_UNDEF_HI, 8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_STOP,     8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_STOP,     8'hFF, 1'b1, 8'hFF, 8'hFF}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_START,    8'hFF, 1'b1, 8'hFF, 8'hFF}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_START,    8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_WRITE,    8'h80, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0},
        '{'{FUNC_WAIT,     8'h01, 1'b0, 8'h00, 8'd1},   1'b1, 8'h00, 1'b0},
        '{'{FUNC_STOP,     8'h00, 1'b0, 8'h00, 8'h00}, 1'b0, 8'h00, 1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [DataW-1:0]  pwdata;
    logic [DataW-1:0]  prdata;
    logic              pready;

    i2cbm_cmd_if cmd_ch ();
    i2cbm_pin_if pin_ch ();

    i2c_bit_level_master_sequencer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .pins    (pin_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bus line model
    logic       line_scl = 1'b1;
    logic       line_sda = 1'b1;
    logic       line_drv = 1'b1;
    logic [7:0] poll_limit = 8'd250;

    pin_upd_t pin_exp [$];
    int       err_cnt = 0;
    int       n_sent = 0;
    bit       idling = 1'b1;
    bit       long_hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic void emit(bit fin = 1'b0, logic [7:0] rx = 8'h00, bit fail = 1'b0);
        pin_upd_t u;
        u.scl_level = line_scl;
        u.sda_level = line_sda;
        u.sda_drive = line_drv;
        u.rx_byte = fin ? rx : 8'h00;
        u.ack_failed = fin & fail;
        u.last = fin;
        pin_exp.push_back(u);
    endfunction

    function automatic void emit_stop(bit fail);
        line_drv = 1'b1;
        line_scl = 1'b0;
        emit();
        line_sda = 1'b0;
        emit();
        line_scl = 1'b1;
        emit();
        line_sda = 1'b1;
        emit(1'b1, 8'h00, fail);
    endfunction

    function automatic void emit_ack(bit ack, logic [7:0] rx);
        line_scl = 1'b0;
        emit();
        line_drv = 1'b1;
        line_sda = ~ack;
        emit();
        line_scl = 1'b1;
        emit();
        line_scl = 1'b0;
        emit(1'b1, rx, 1'b0);
    endfunction

    function automatic void expand_cmd(bus_cmd_t c);
        logic [7:0] sh;
        bit         fail;
        int         i;
        sh = c.tx_byte;
        case (c.func)
            FUNC_START:
            begin
                line_drv = 1'b1;
                line_sda = 1'b1;
                emit();
                line_scl = 1'b1;
                emit();
                line_sda = 1'b0;
                emit();
                line_scl = 1'b0;
                emit(1'b1);
            end
            FUNC_STOP:
                emit_stop(1'b0);
            FUNC_WAIT:
            begin
                line_drv = 1'b0;
                line_sda = 1'b1;
                emit();
                line_scl = 1'b1;
                emit();
                fail = (c.sda_high_polls > poll_limit) || (c.sda_high_polls == NEVER_LOW);
                if (fail)
                    emit_stop(1'b1);
                else
                begin
                    line_scl = 1'b0;
                    emit(1'b1);
                end
            end
            FUNC_ACK:
                emit_ack(c.ack_choice, 8'h00);
            FUNC_WRITE:
            begin
                line_drv = 1'b1;
                line_scl = 1'b0;
                emit();
                for (i = 0; i < 8; i++)
                begin
                    line_sda = sh[7];
                    sh = sh << 1;
                    emit();
                    line_scl = 1'b1;
                    emit();
                    line_scl = 1'b0;
                    emit(i == 7);
                end
            end
            FUNC_READ:
            begin
                line_drv = 1'b0;
                for (i = 0; i < 8; i++)
                begin
                    line_scl = 1'b0;
                    emit();
                    line_scl = 1'b1;
                    emit();
                end
                emit_ack(c.ack_choice, c.rx_bits);
            end
            default:
                ;
        endcase
    endfunction

    function automatic logic [7:0] pick_polls();
        case ($urandom_range(0, 8))
            0: return 8'd0;
            1: return poll_limit;
            2: return (poll_limit == 8'hFF) ? 8'hFF : poll_limit + 8'd1;
            3: return NEVER_LOW;
            8: return 8'($urandom);
            default: return 8'($urandom_range(0, poll_limit));
        endcase
    endfunction

    function automatic bus_cmd_t rand_cmd(logic [2:0] f);
        bus_cmd_t c;
        c.func = f;
        c.tx_byte = 8'($urandom);
        c.ack_choice = 1'($urandom);
        c.rx_bits = 8'($urandom);
        c.sda_high_polls = pick_polls();
        return c;
    endfunction

    // valid stays high between back-to-back items; lowered for a gap or a drain
    task automatic send_cmd(input bus_cmd_t c);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= c.func;
        cmd_ch.tx_byte <= c.tx_byte;
        cmd_ch.ack_choice <= c.ack_choice;
        cmd_ch.rx_bits <= c.rx_bits;
        cmd_ch.sda_high_polls <= c.sda_high_polls;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        expand_cmd(c);
        if (c.func <= FUNC_READ)
            n_sent++;
    endtask

    task automatic send_poll(input logic [7:0] p);
        bus_cmd_t c;
        c = rand_cmd(FUNC_WAIT);
        c.sda_high_polls = p;
        send_cmd(c);
    endtask

    // start, address, ack, a few data bytes, usually a stop
    task automatic send_transfer();
        bus_cmd_t c;
        bit       rd;
        int       nbytes;
        int       i;
        send_cmd(rand_cmd(FUNC_START));
        c = rand_cmd(FUNC_WRITE);
        rd = c.tx_byte[0];
        send_cmd(c);
        send_cmd(rand_cmd(FUNC_WAIT));
        nbytes = $urandom_range(1, 3);
        for (i = 0; i < nbytes; i++)
        begin
            if (rd)
            begin
                c = rand_cmd(FUNC_READ);
                if ($urandom_range(0, 7) != 0)
                    c.ack_choice = (i != nbytes - 1);
                send_cmd(c);
            end
            else
            begin
                send_cmd(rand_cmd(FUNC_WRITE));
                send_cmd(rand_cmd(FUNC_WAIT));
            end
        end
        if ($urandom_range(0, 4) != 0)
            send_cmd(rand_cmd(FUNC_STOP));
    endtask

    task automatic run_random(input int target);
        while (n_sent < target)
        begin
            if ($urandom_range(0, 3) != 0)
                send_transfer();
            else
                send_cmd(rand_cmd(3'($urandom_range(0, 7))));
        end
    endtask

    task automatic drain_pins();
        int k;
        cmd_ch.valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pin_exp.size() != 0; k++)
            @(posedge clk);
        if (pin_exp.size() != 0)
        begin
            report("pin updates never seen", 0, pin_exp.size());
            pin_exp.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (a == ADDR_POLL_LIMIT)
            poll_limit = d[7:0];
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [AddrW-1:0] a, input logic [DataW-1:0] want);
        logic [DataW-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report("prdata", got, want);
        @(posedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        apb_write(ADDR_POLL_LIMIT, {24'h0, v});
        apb_check(ADDR_POLL_LIMIT, {24'h0, v});
    endtask

    task automatic check_pin();
        pin_upd_t want;
        if (pin_exp.size() == 0)
            report("pin update with none pending", pin_ch.scl_level, 0);
        else
        begin
            want = pin_exp.pop_front();
            if (pin_ch.scl_level !== want.scl_level)
                report("scl_level", pin_ch.scl_level, want.scl_level);
            if (pin_ch.sda_level !== want.sda_level)
                report("sda_level", pin_ch.sda_level, want.sda_level);
            if (pin_ch.sda_drive !== want.sda_drive)
                report("sda_drive", pin_ch.sda_drive, want.sda_drive);
            if (pin_ch.rx_byte !== want.rx_byte)
                report("rx_byte", pin_ch.rx_byte, want.rx_byte);
            if (pin_ch.ack_failed !== want.ack_failed)
                report("ack_failed", pin_ch.ack_failed, want.ack_failed);
            if (pin_ch.last !== want.last)
                report("last", pin_ch.last, want.last);
        end
    endtask

    initial
    begin : pin_sink
        int stall;
        bit rdy;
        stall = 0;
        pin_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pin_ch.valid && pin_ch.ready)
                check_pin();
            if (stall > 0)
            begin
                stall--;
                rdy = (stall == 0);
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
                rdy = 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 19);
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            pin_ch.ready <= rdy;
        end
    end

    initial
    begin : stimulus
        int k;
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= FUNC_START;
        cmd_ch.tx_byte <= 8'h00;
        cmd_ch.ack_choice <= 1'b0;
        cmd_ch.rx_bits <= 8'h00;
        cmd_ch.sda_high_polls <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_check(ADDR_POLL_LIMIT, 32'd250);
        for (k = 0; k < NDIR; k++)
        begin
            send_cmd(dir_rows[k].c);
            if (dir_rows[k].typed)
            begin
                pin_exp[pin_exp.size() - 1].rx_byte = dir_rows[k].exp_rx;
                pin_exp[pin_exp.size() - 1].ack_failed = dir_rows[k].exp_fail;
            end
        end
        drain_pins();

        set_limit(8'd0);
        send_poll(8'd0);
        send_poll(8'd1);
        run_random(90);
        drain_pins();

        // unmapped write must leave the limit alone
        apb_write(ADDR_UNMAPPED, $urandom);
        apb_check(ADDR_POLL_LIMIT, 32'd0);
        set_limit(8'd255);
        send_poll(8'd254);
        send_poll(8'd255);
        long_hold_req = 1'b1;
        run_random(190);
        drain_pins();

        set_limit(8'($urandom_range(1, 254)));
        run_random(330);
        drain_pins();

        idling = 1'b0;
        set_limit(8'd250);
        run_random(410);
        drain_pins();

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
